@@ hdl/hexrec_pkg.sv @@
// ----------------------------------------------------------------------------
// hexrec_pkg
// Types, constants and the character-to-digit map of the HEX record decoder.
// ----------------------------------------------------------------------------
package hexrec_pkg;

  localparam logic [9:0] COUNT_MAX  = 10'd1023;
  localparam logic [8:0] PAIR_MAX   = 9'd511;
  localparam logic [8:0] HDR_PAIRS  = 9'd4;
  localparam logic [8:0] FRAME_BYTES = 9'd5;
  localparam logic [8:0] MAX_CHARS_RST = 9'd511;
  localparam logic [8:0] MIN_CHARS_RST = 9'd11;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] DIGIT_BAD  = 8'hff;
  localparam logic [7:0] LETTER_OFS = 8'd10;

  typedef enum logic {
    CFG_MAX_CHARS = 1'b0,
    CFG_MIN_CHARS = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LONG  = 3'd1,
    ST_TOO_SHORT = 3'd2,
    ST_NO_COLON  = 3'd3,
    ST_LEN_ERR   = 3'd4,
    ST_SUM_ERR   = 3'd5,
    ST_TYPE_ERR  = 3'd6
  } status_t;

  typedef enum logic {
    KIND_BYTE   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef enum logic [7:0] {
    REC_DATA     = 8'd0,
    REC_EOF      = 8'd1,
    REC_EXT_SEG  = 8'd2,
    REC_EXT_LIN  = 8'd4
  } rec_type_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_value;
    logic [7:0]  byte_index;
    logic [7:0]  record_length;
    logic [15:0] load_address;
    logic [7:0]  record_type;
    status_t     status;
  } result_t;

  function automatic logic [7:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    if (c >= "0" && c <= "9") begin
      d = c - 8'("0");
    end else if (c >= "a" && c <= "z") begin
      d = c - 8'("a") + LETTER_OFS;
    end else if (c >= "A" && c <= "Z") begin
      d = c - 8'("A") + LETTER_OFS;
    end else begin
      d = DIGIT_BAD;
    end
    return d;
  endfunction

endpackage

@@ hdl/hexrec_core.sv @@
// ----------------------------------------------------------------------------
// hexrec_core
// Line state, byte assembly, header capture and end-of-record status.
// ----------------------------------------------------------------------------
module hexrec_core import hexrec_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       beat_fire,
  input  logic [7:0] char_code,
  input  logic       end_of_line,
  output logic       res_valid,
  output result_t    res
);

  logic [8:0]  max_chars_r, min_chars_r;
  logic [9:0]  char_count_r, char_count_nxt;
  logic [7:0]  high_digit_r, high_digit_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic [8:0]  pair_count_r, pair_count_nxt;
  logic [7:0]  hdr_len_r, hdr_len_nxt;
  logic [15:0] hdr_addr_r, hdr_addr_nxt;
  logic [7:0]  hdr_type_r, hdr_type_nxt;
  logic        colon_seen_r, colon_seen_nxt;

  logic       have_byte;
  logic [7:0] byte_val, byte_idx, cur_byte;
  status_t    status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chars_r <= MAX_CHARS_RST;
      min_chars_r <= MIN_CHARS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MAX_CHARS: max_chars_r <= cfg_data;
        CFG_MIN_CHARS: min_chars_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    char_count_nxt  = char_count_r;
    high_digit_nxt  = high_digit_r;
    running_sum_nxt = running_sum_r;
    pair_count_nxt  = pair_count_r;
    hdr_len_nxt     = hdr_len_r;
    hdr_addr_nxt    = hdr_addr_r;
    hdr_type_nxt    = hdr_type_r;
    colon_seen_nxt  = colon_seen_r;
    have_byte       = 1'b0;
    byte_val        = '0;
    byte_idx        = '0;
    cur_byte        = {high_digit_r[3:0], 4'h0} | digit_of(char_code);

    // characters past saturation are dropped
    if (char_count_r != COUNT_MAX) begin
      char_count_nxt = char_count_r + 10'd1;
      if (char_count_r == '0) begin
        colon_seen_nxt = (char_code == CHAR_COLON);
      end else if (char_count_r[0]) begin
        high_digit_nxt = digit_of(char_code);
      end else begin
        running_sum_nxt = running_sum_r + cur_byte;
        case (pair_count_r)
          9'd0: hdr_len_nxt = cur_byte;
          9'd1: hdr_addr_nxt = {cur_byte, hdr_addr_r[7:0]};
          9'd2: hdr_addr_nxt = {hdr_addr_r[15:8], cur_byte};
          9'd3: hdr_type_nxt = cur_byte;
          default: begin
            have_byte = 1'b1;
            byte_val  = cur_byte;
            byte_idx  = 8'(pair_count_r - HDR_PAIRS);
          end
        endcase
        if (pair_count_r != PAIR_MAX) begin
          pair_count_nxt = pair_count_r + 9'd1;
        end
      end
    end

    if (char_count_nxt > {1'b0, max_chars_r}) begin
      status = ST_TOO_LONG;
    end else if (char_count_nxt < {1'b0, min_chars_r}) begin
      status = ST_TOO_SHORT;
    end else if (!colon_seen_nxt) begin
      status = ST_NO_COLON;
    end else if (!char_count_nxt[0]) begin
      // even total means an odd count after the colon
      status = ST_LEN_ERR;
    end else if (pair_count_nxt < FRAME_BYTES ||
                 {1'b0, hdr_len_nxt} != pair_count_nxt - FRAME_BYTES) begin
      status = ST_LEN_ERR;
    end else if (running_sum_nxt != '0) begin
      status = ST_SUM_ERR;
    end else if (hdr_type_nxt != REC_DATA && hdr_type_nxt != REC_EOF &&
                 hdr_type_nxt != REC_EXT_SEG && hdr_type_nxt != REC_EXT_LIN) begin
      status = ST_TYPE_ERR;
    end else begin
      status = ST_OK;
    end

    res_valid = beat_fire && (end_of_line || have_byte);
    res.byte_value = byte_val;
    res.byte_index = byte_idx;
    if (end_of_line) begin
      res.kind          = KIND_STATUS;
      res.record_length = hdr_len_nxt;
      res.load_address  = hdr_addr_nxt;
      res.record_type   = hdr_type_nxt;
      res.status        = status;
    end else begin
      res.kind          = KIND_BYTE;
      res.record_length = '0;
      res.load_address  = '0;
      res.record_type   = '0;
      res.status        = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (beat_fire && end_of_line)) begin
      char_count_r  <= '0;
      high_digit_r  <= '0;
      running_sum_r <= '0;
      pair_count_r  <= '0;
      hdr_len_r     <= '0;
      hdr_addr_r    <= '0;
      hdr_type_r    <= '0;
      colon_seen_r  <= 1'b0;
    end else if (beat_fire) begin
      char_count_r  <= char_count_nxt;
      high_digit_r  <= high_digit_nxt;
      running_sum_r <= running_sum_nxt;
      pair_count_r  <= pair_count_nxt;
      hdr_len_r     <= hdr_len_nxt;
      hdr_addr_r    <= hdr_addr_nxt;
      hdr_type_r    <= hdr_type_nxt;
      colon_seen_r  <= colon_seen_nxt;
    end
  end

endmodule

@@ hdl/hexrec_outq.sv @@
// ----------------------------------------------------------------------------
// hexrec_outq
// Two-entry result register with skid slot toward the output channel.
// ----------------------------------------------------------------------------
module hexrec_outq import hexrec_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic [1:0] count_r, count_nxt;
  result_t    head_r, tail_r;
  logic       pop;

  assign pop       = (count_r != 2'd0) && !out_stall;
  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = head_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      head_r <= (count_r == 2'd2) ? tail_r : push_data;
    end else if (push && count_r == 2'd0) begin
      head_r <= push_data;
    end
    // second slot fills when head stays occupied
    if (push && ((count_r == 2'd1 && !pop) || count_r == 2'd2)) begin
      tail_r <= push_data;
    end
  end

endmodule

@@ hdl/intel_hex_record_decoder.sv @@
// ----------------------------------------------------------------------------
// intel_hex_record_decoder
// Decodes HEX record lines one character per beat into data bytes and a
// per-line status result.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  char_code, end_of_line
//   out_     output     out_valid / out_stall result fields, one per result
//   cfg_     input      cfg_wr_en            cfg_index, cfg_data
//
// One character per cycle while in_stall is low; each input beat passes the
// input register, then decode into the result register.
// Synchronous active-low reset clears line state and restores the limits.
// A two-entry result register absorbs one stalled result, so input keeps
// flowing; in_stall rises only when both result slots are held.
// ----------------------------------------------------------------------------
module intel_hex_record_decoder import hexrec_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [7:0]  out_byte_value,
  output logic [7:0]  out_byte_index,
  output logic [7:0]  out_record_length,
  output logic [15:0] out_load_address,
  output logic [7:0]  out_record_type,
  output logic [2:0]  out_status,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);

  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_eol_r;
  logic       q_full, s1_adv, res_valid;
  result_t    res, head;

  assign s1_adv   = s1_valid_r && !q_full;
  assign in_stall = s1_valid_r && q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_char_r <= in_char_code;
      s1_eol_r  <= in_end_of_line;
    end
  end

  hexrec_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .beat_fire  (s1_adv),
    .char_code  (s1_char_r),
    .end_of_line(s1_eol_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  hexrec_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_data(res),
    .full     (q_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (head)
  );

  assign out_result_kind   = head.kind;
  assign out_byte_value    = head.byte_value;
  assign out_byte_index    = head.byte_index;
  assign out_record_length = head.record_length;
  assign out_load_address  = head.load_address;
  assign out_record_type   = head.record_type;
  assign out_status        = head.status;

endmodule
